[hw/rtl/lidar_frame_receiver_assert.svh]
// Assertion macros for the lidar frame receiver.
// Used by the top level; relies on signals named clk and rst in the including scope.
`ifndef LIDAR_FRAME_RECEIVER_ASSERT_SVH
`define LIDAR_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/lfr_pkg.sv]
// Shared types and constants for the lidar frame receiver.
// No dependencies; used by every module of the block.
`default_nettype none

package lfr_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned NIB_W     = 4;
  localparam int unsigned POS_W     = 6;
  localparam int unsigned CFG_IDX_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_HEADER  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_HEADER = 8'd1;

  // Reset values of the header nibbles.
  localparam logic [NIB_W-1:0] FIRST_HEADER_RESET  = 4'hA;
  localparam logic [NIB_W-1:0] SECOND_HEADER_RESET = 4'h5;

  // Fixed frame positions.
  localparam logic [POS_W-1:0] POS_FIRST_HEADER  = 6'd0;
  localparam logic [POS_W-1:0] POS_SECOND_HEADER = 6'd1;
  localparam logic [POS_W-1:0] POS_FIRST_DATA    = 6'd2;
  localparam logic [POS_W-1:0] POS_SECOND_DATA   = 6'd3;

  typedef struct packed {
    logic [NIB_W-1:0] first_header_nibble;
    logic [NIB_W-1:0] second_header_nibble;
  } lfr_cfg_t;

  typedef struct packed {
    logic              stored;
    logic [POS_W-1:0]  position;
    logic [BYTE_W-1:0] frame_byte;
    logic              frame_end;
    logic              checksum_good;
  } lfr_result_t;

endpackage

`default_nettype wire

[hw/rtl/lfr_frame_tracker.sv]
// Frame position tracker: header match, running XOR and check value.
// Depends on lfr_pkg for the config and result structs.
`default_nettype none

module lfr_frame_tracker #(
  parameter int unsigned FRAME_LEN = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               beat,
  input  wire logic [7:0]         rx_byte,
  input  wire lfr_pkg::lfr_cfg_t  cfg,
  output lfr_pkg::lfr_result_t    result
);

  localparam logic [lfr_pkg::POS_W-1:0] LAST_POS = lfr_pkg::POS_W'(FRAME_LEN - 1);

  logic [lfr_pkg::POS_W-1:0]  byte_count;
  logic [lfr_pkg::POS_W-1:0]  byte_count_next;
  logic [lfr_pkg::BYTE_W-1:0] running_xor;
  logic [lfr_pkg::BYTE_W-1:0] running_xor_next;
  logic [lfr_pkg::BYTE_W-1:0] expected_check;
  logic [lfr_pkg::BYTE_W-1:0] expected_check_next;
  logic [lfr_pkg::NIB_W-1:0]  hi_nib;
  logic [lfr_pkg::NIB_W-1:0]  lo_nib;

  assign hi_nib = rx_byte[7:4];
  assign lo_nib = rx_byte[3:0];

  always_comb begin
    byte_count_next      = byte_count;
    running_xor_next     = running_xor;
    expected_check_next  = expected_check;
    result.stored        = 1'b0;
    result.position      = lfr_pkg::POS_FIRST_HEADER;
    result.frame_byte    = rx_byte;
    result.frame_end     = 1'b0;
    result.checksum_good = 1'b0;
    if (byte_count == lfr_pkg::POS_FIRST_HEADER) begin
      if (hi_nib == cfg.first_header_nibble) begin
        result.stored       = 1'b1;
        expected_check_next = {4'h0, lo_nib};
        byte_count_next     = lfr_pkg::POS_SECOND_HEADER;
      end
    end else if (byte_count == lfr_pkg::POS_SECOND_HEADER) begin
      // A failed second header sends us back to hunting; this byte is dropped.
      if (hi_nib == cfg.second_header_nibble) begin
        result.stored       = 1'b1;
        result.position     = lfr_pkg::POS_SECOND_HEADER;
        expected_check_next = {lo_nib, expected_check[3:0]};
        byte_count_next     = lfr_pkg::POS_FIRST_DATA;
      end else begin
        byte_count_next = lfr_pkg::POS_FIRST_HEADER;
      end
    end else if (byte_count == lfr_pkg::POS_FIRST_DATA) begin
      result.stored    = 1'b1;
      result.position  = lfr_pkg::POS_FIRST_DATA;
      running_xor_next = rx_byte;
      byte_count_next  = lfr_pkg::POS_SECOND_DATA;
    end else if (byte_count < LAST_POS) begin
      result.stored    = 1'b1;
      result.position  = byte_count;
      running_xor_next = running_xor ^ rx_byte;
      byte_count_next  = byte_count + 1'b1;
    end else begin
      result.stored        = 1'b1;
      result.position      = byte_count;
      running_xor_next     = running_xor ^ rx_byte;
      byte_count_next      = lfr_pkg::POS_FIRST_HEADER;
      result.frame_end     = 1'b1;
      result.checksum_good = (running_xor_next == expected_check);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= lfr_pkg::POS_FIRST_HEADER;
      running_xor    <= '0;
      expected_check <= '0;
    end else if (beat) begin
      byte_count     <= byte_count_next;
      running_xor    <= running_xor_next;
      expected_check <= expected_check_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/lfr_out_skid.sv]
// Two-entry result buffer: an output register backed by a skid register.
// Depends on lfr_pkg for the result struct.
`default_nettype none

module lfr_out_skid (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_beat,
  input  wire lfr_pkg::lfr_result_t in_result,
  output logic                      space,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output lfr_pkg::lfr_result_t      out_result
);

  lfr_pkg::lfr_result_t skid_result;
  logic                 skid_valid;
  logic                 out_free;

  // The upstream side stalls only when both entries are full.
  assign space    = !skid_valid;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid  <= skid_valid || in_beat;
        skid_valid <= 1'b0;
      end else if (in_beat) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_result <= skid_result;
      end else if (in_beat) begin
        out_result <= in_result;
      end
    end else if (in_beat) begin
      skid_result <= in_result;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/lidar_frame_receiver.sv]
// Top level of the lidar frame receiver: config registers, tracker and result buffer.
// Depends on lfr_pkg, lfr_frame_tracker, lfr_out_skid and lidar_frame_receiver_assert.svh.
`default_nettype none

// Byte-serial frame receiver. Each accepted rx_byte beat yields exactly one result
// beat, and a new byte is taken every cycle unless the output buffer is full: the
// frame state is a byte-wise update, and a two-entry buffer keeps in_ready high
// while one result waits downstream. Frames are FRAME_LEN bytes; bytes 0 and 1 must
// carry the configured header nibbles in their high halves, and the XOR of bytes 2
// through FRAME_LEN-1 is checked against the low nibbles of bytes 1 and 0. Config
// writes (cfg_index 0 and 1, low four bits of cfg_data) are always accepted, are
// meant for idle periods, and ignore other indexes.
module lidar_frame_receiver #(
  parameter int unsigned FRAME_LEN = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            stored,
  output logic [5:0]      position,
  output logic [7:0]      frame_byte,
  output logic            frame_end,
  output logic            checksum_good,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  lfr_pkg::lfr_cfg_t    cfg;
  lfr_pkg::lfr_result_t track_result;
  lfr_pkg::lfr_result_t out_result;
  logic                 in_beat;

  assign cfg_ready = 1'b1;
  assign in_beat   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_header_nibble  <= lfr_pkg::FIRST_HEADER_RESET;
      cfg.second_header_nibble <= lfr_pkg::SECOND_HEADER_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        lfr_pkg::CFG_FIRST_HEADER:  cfg.first_header_nibble  <= cfg_data[3:0];
        lfr_pkg::CFG_SECOND_HEADER: cfg.second_header_nibble <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  lfr_frame_tracker #(
    .FRAME_LEN(FRAME_LEN)
  ) u_tracker (
    .clk     (clk),
    .rst     (rst),
    .beat    (in_beat),
    .rx_byte (rx_byte),
    .cfg     (cfg),
    .result  (track_result)
  );

  lfr_out_skid u_out (
    .clk        (clk),
    .rst        (rst),
    .in_beat    (in_beat),
    .in_result  (track_result),
    .space      (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result)
  );

  assign stored        = out_result.stored;
  assign position      = out_result.position;
  assign frame_byte    = out_result.frame_byte;
  assign frame_end     = out_result.frame_end;
  assign checksum_good = out_result.checksum_good;

`include "lidar_frame_receiver_assert.svh"

  `LFR_ASSERT_NOW(a_end_is_stored, out_valid && frame_end, stored, "frame end on unstored byte")
  `LFR_ASSERT_NOW(a_good_needs_end, out_valid && checksum_good, frame_end, "verdict without end")
  `LFR_ASSERT_NOW(a_unstored_pos, out_valid && !stored, position == 6'd0, "unstored byte position")
  `LFR_ASSERT_NOW(a_stall_means_full, !in_ready, out_valid, "input stalled with empty output")
  `LFR_ASSERT_NEXT(a_beat_gives_result, in_beat, out_valid, "accepted byte produced no result")

endmodule

`default_nettype wire

[bench/tb_lidar_frame_receiver.sv]
`timescale 1ns / 1ps
// Self-checking testbench for lidar_frame_receiver: directed and random byte streams,
// every result beat compared with a frame tracker predictor. Depends on lfr_pkg and the RTL.

module tb_lidar_frame_receiver;

  localparam int unsigned FRAME_LEN    = 64;
  localparam int          IDLE_PCT     = 34;
  localparam int          STALL_LIMIT  = 2000;
  localparam int          RANDOM_BEATS = 1060;

  // Indexes outside the register map; writes to them must be dropped.
  localparam logic [lfr_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_LOW = 8'd2;
  localparam logic [lfr_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_TOP = 8'hFF;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       stored;
  logic [5:0] position;
  logic [7:0] frame_byte;
  logic       frame_end;
  logic       checksum_good;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_index = 8'h00;
  logic [7:0] cfg_data = 8'h00;

  lidar_frame_receiver #(.FRAME_LEN(FRAME_LEN)) u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .stored(stored), .position(position), .frame_byte(frame_byte),
    .frame_end(frame_end), .checksum_good(checksum_good),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor copy of the header registers and the frame tracker state.
  lfr_pkg::lfr_cfg_t          hdr_cfg;
  logic [lfr_pkg::POS_W-1:0]  trk_count;
  logic [7:0]                 trk_xor;
  logic [7:0]                 trk_check;

  lfr_pkg::lfr_result_t expected_q[$];
  lfr_pkg::lfr_result_t want_beat;
  int          fail_count   = 0;
  int          beats_sent   = 0;
  int          quiet_cycles = 0;
  bit          steady_in    = 1'b0;
  bit          steady_out   = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Advances the tracker by one received byte and returns the result it causes.
  function automatic lfr_pkg::lfr_result_t track_byte(input logic [7:0] b);
    lfr_pkg::lfr_result_t r;
    r = '0;
    r.frame_byte = b;
    if (trk_count == 6'd0) begin
      if (b[7:4] == hdr_cfg.first_header_nibble) begin
        r.stored   = 1'b1;
        r.position = lfr_pkg::POS_FIRST_HEADER;
        trk_check  = {4'h0, b[3:0]};
        trk_count  = 6'd1;
      end
    end else if (trk_count == 6'd1) begin
      if (b[7:4] == hdr_cfg.second_header_nibble) begin
        r.stored   = 1'b1;
        r.position = lfr_pkg::POS_SECOND_HEADER;
        trk_check  = {b[3:0], trk_check[3:0]};
        trk_count  = 6'd2;
      end else begin
        trk_count = 6'd0;
      end
    end else if (trk_count == 6'd2) begin
      r.stored   = 1'b1;
      r.position = lfr_pkg::POS_FIRST_DATA;
      trk_xor    = b;
      trk_count  = 6'd3;
    end else begin
      r.stored   = 1'b1;
      r.position = trk_count;
      trk_xor    = trk_xor ^ b;
      if (trk_count < FRAME_LEN - 1) begin
        trk_count = trk_count + 6'd1;
      end else begin
        trk_count       = 6'd0;
        r.frame_end     = 1'b1;
        r.checksum_good = (trk_xor == trk_check);
      end
    end
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while (!steady_in && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(track_byte(b));
    beats_sent++;
  endtask

  // Stops sending and waits until every predicted result beat has been taken.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  task automatic write_reg(input logic [lfr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == lfr_pkg::CFG_FIRST_HEADER) begin
      hdr_cfg.first_header_nibble = data[3:0];
    end else if (idx == lfr_pkg::CFG_SECOND_HEADER) begin
      hdr_cfg.second_header_nibble = data[3:0];
    end
    @(posedge clk);
  endtask

  // Feeds filler until the tracker is back to hunting for a first header.
  task automatic hunt_sync();
    while (trk_count != 6'd0) begin
      if (trk_count == 6'd1) begin
        send_byte({~hdr_cfg.second_header_nibble, 4'($urandom)});
      end else begin
        send_byte(8'($urandom));
      end
    end
  endtask

  // A whole frame under the current headers; fill < 0 gives random payload bytes.
  task automatic send_frame(input bit good_sum, input int fill);
    logic [3:0] lo0;
    logic [3:0] lo1;
    logic [7:0] acc;
    logic [7:0] b;
    hunt_sync();
    lo0 = 4'($urandom);
    lo1 = 4'($urandom);
    acc = 8'h00;
    send_byte({hdr_cfg.first_header_nibble, lo0});
    send_byte({hdr_cfg.second_header_nibble, lo1});
    for (int i = 2; i < FRAME_LEN - 1; i++) begin
      b   = (fill < 0) ? 8'($urandom) : 8'(fill);
      acc = acc ^ b;
      send_byte(b);
    end
    if (good_sum) begin
      send_byte(acc ^ {lo1, lo0});
    end else begin
      send_byte(acc ^ {lo1, lo0} ^ 8'($urandom_range(1, 255)));
    end
  endtask

  task automatic test_hunt_and_header_reject();
    steady_in  = 1'b1;
    steady_out = 1'b1;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);
    send_byte(8'hA7);
    // The rejected second byte carries the first header nibble but must not restart a frame.
    send_byte(8'hA3);
    send_byte(8'h51);
    send_byte(8'hA0);
    send_byte(8'h5F);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    steady_in  = 1'b0;
    steady_out = 1'b0;
    hunt_sync();
    settle();
    write_reg(CFG_UNMAPPED_LOW, 8'hFF);
    write_reg(CFG_UNMAPPED_TOP, 8'h00);
  endtask

  task automatic test_full_frames();
    steady_in  = 1'b1;
    steady_out = 1'b1;
    send_frame(1'b1, 8'h00);
    send_frame(1'b0, 8'hFF);
    steady_in  = 1'b0;
    steady_out = 1'b0;
    send_frame(1'b1, -1);
    send_frame(1'b0, -1);
    send_frame(1'b1, -1);
  endtask

  task automatic test_header_settings();
    settle();
    write_reg(lfr_pkg::CFG_FIRST_HEADER, 8'h00);
    write_reg(lfr_pkg::CFG_SECOND_HEADER, 8'hFF);
    send_frame(1'b1, -1);
    send_frame(1'b0, -1);
    settle();
    // Upper data bits are dropped by the register write.
    write_reg(lfr_pkg::CFG_FIRST_HEADER, 8'h0F);
    write_reg(lfr_pkg::CFG_SECOND_HEADER, 8'hF0);
    send_frame(1'b1, -1);
    send_frame(1'b0, 8'h00);
    // A header change in the middle of a frame only applies to the next one.
    send_byte({hdr_cfg.first_header_nibble, 4'h3});
    send_byte({hdr_cfg.second_header_nibble, 4'hC});
    repeat (10) send_byte(8'($urandom));
    settle();
    write_reg(lfr_pkg::CFG_FIRST_HEADER, 8'h37);
    hunt_sync();
    send_frame(1'b1, -1);
    settle();
    write_reg(lfr_pkg::CFG_SECOND_HEADER, 8'h7B);
    send_frame(1'b1, -1);
  endtask

  task automatic test_random_stream();
    int         start;
    int         pick;
    int         n;
    logic [3:0] nib;
    start = beats_sent;
    while (beats_sent - start < RANDOM_BEATS) begin
      steady_in  = (beats_sent - start >= 400) && (beats_sent - start < 650);
      steady_out = steady_in;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_frame($urandom_range(0, 1), -1);
      end else if (pick < 72) begin
        hunt_sync();
        send_byte({hdr_cfg.first_header_nibble, 4'($urandom)});
        nib = 4'($urandom);
        if (nib == hdr_cfg.second_header_nibble) begin
          nib = ~nib;
        end
        send_byte({nib, 4'($urandom)});
      end else if (pick < 82) begin
        // Cut-short frame: whatever follows is absorbed as payload.
        hunt_sync();
        send_byte({hdr_cfg.first_header_nibble, 4'($urandom)});
        send_byte({hdr_cfg.second_header_nibble, 4'($urandom)});
        n = $urandom_range(1, 40);
        repeat (n) send_byte(8'($urandom));
      end else if (pick < 92) begin
        n = $urandom_range(1, 8);
        repeat (n) send_byte(8'($urandom));
      end else begin
        settle();
        if ($urandom_range(0, 3) == 0) begin
          write_reg(8'($urandom_range(2, 255)), 8'($urandom));
        end else if ($urandom_range(0, 1) == 0) begin
          write_reg(lfr_pkg::CFG_FIRST_HEADER, 8'($urandom));
        end else begin
          write_reg(lfr_pkg::CFG_SECOND_HEADER, 8'($urandom));
        end
      end
    end
    steady_in  = 1'b0;
    steady_out = 1'b0;
  endtask

  always @(posedge clk) begin
    out_ready <= steady_out || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: frame_byte %0h", frame_byte);
        fail_count++;
      end else begin
        want_beat = expected_q.pop_front();
        compare_field("stored", 8'(want_beat.stored), 8'(stored));
        compare_field("position", 8'(want_beat.position), 8'(position));
        compare_field("frame_byte", want_beat.frame_byte, frame_byte);
        compare_field("frame_end", 8'(want_beat.frame_end), 8'(frame_end));
        compare_field("checksum_good", 8'(want_beat.checksum_good), 8'(checksum_good));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    hdr_cfg.first_header_nibble  = lfr_pkg::FIRST_HEADER_RESET;
    hdr_cfg.second_header_nibble = lfr_pkg::SECOND_HEADER_RESET;
    trk_count = 6'd0;
    trk_xor   = 8'h00;
    trk_check = 8'h00;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_hunt_and_header_reject();
    test_full_frames();
    test_header_settings();
    test_random_stream();
    settle();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/lfr_pkg.sv
hw/rtl/lfr_frame_tracker.sv
hw/rtl/lfr_out_skid.sv
hw/rtl/lidar_frame_receiver.sv
bench/tb_lidar_frame_receiver.sv
